// ----- hdl/tfn_pkg.sv -----
// shared types, constants and helpers of the triangle face normal unit
`default_nettype none

package tfn_pkg;

  localparam int VERTEX_DEPTH = 4096;
  localparam int ADDR_W       = $clog2(VERTEX_DEPTH);
  localparam int IDX_W        = 12;
  localparam int POS_W        = 24;
  localparam int DIFF_W       = POS_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int CROSS_W      = PROD_W + 1;
  localparam int NRM_W        = 16;
  localparam int NRM_FRAC     = 14;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_TRI  = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [IDX_W-1:0]        index_a;
    logic [IDX_W-1:0]        index_b;
    logic [IDX_W-1:0]        index_c;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } req_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic                    degenerate;
  } res_t;

  typedef logic signed [CROSS_W-1:0] cross_t;

  typedef struct packed {
    cross_t cx;
    cross_t cy;
    cross_t cz;
  } cross_vec_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_RDN, S_RDN_W, S_RD_A, S_RD_B, S_RD_C, S_CAP,
    S_DIFF, S_MUL, S_NSTART, S_NWAIT, S_WR_A, S_WR_B, S_WR_C, S_EMIT
  } tfn_state_t;

  typedef enum logic [3:0] {
    N_IDLE, N_MAX, N_SHIFT, N_SQ, N_SQRT, N_DIV_INIT, N_DIV_STEP,
    N_DIV_STORE, N_DONE
  } norm_state_t;

  function automatic logic in_store(input logic [IDX_W-1:0] idx);
    return 32'(idx) < 32'(VERTEX_DEPTH);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/tfn_norm.sv -----
// normalizer: cross product to unit normal by shift, square sum, root and divide
`default_nettype none

module tfn_norm (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire tfn_pkg::cross_vec_t cvec,
  output logic                   done,
  output tfn_pkg::res_t          res
);
  import tfn_pkg::*;

  norm_state_t state, state_next;

  logic [CROSS_W-1:0] mag [3];
  logic               sgn [3];
  logic [CROSS_W-1:0] m;
  logic [CROSS_W-1:0] m_max;

  logic [1:0]  sq_k;
  logic [29:0] sq_op;
  logic [59:0] sq_prod;
  logic [63:0] sum;

  logic [63:0] s_rem;
  logic [63:0] root;
  logic [63:0] bitv;
  logic [63:0] trial_sq;

  logic [31:0] len;
  logic [1:0]  dv_j;
  logic [3:0]  dv_i;
  logic [45:0] rem;
  logic [45:0] trial_dv;
  logic [14:0] q;
  logic [29:0] dv_op;
  logic signed [NRM_W-1:0] nval;

  logic m_big;
  logic m_small;

  always_comb begin
    m_max = mag[0];
    if (mag[1] > m_max) begin
      m_max = mag[1];
    end
    if (mag[2] > m_max) begin
      m_max = mag[2];
    end
  end

  assign m_big   = m[CROSS_W-1:30] != '0;
  assign m_small = !m_big && !m[29];

  always_comb begin
    unique case (sq_k)
      2'd0:    sq_op = mag[0][29:0];
      2'd1:    sq_op = mag[1][29:0];
      2'd2:    sq_op = mag[2][29:0];
      default: sq_op = '0;
    endcase
  end

  always_comb begin
    unique case (dv_j)
      2'd0:    dv_op = mag[0][29:0];
      2'd1:    dv_op = mag[1][29:0];
      default: dv_op = mag[2][29:0];
    endcase
  end

  assign trial_sq = root + bitv;
  assign trial_dv = 46'(len) << dv_i;

  always_comb begin
    unique case (dv_j)
      2'd0:    nval = sgn[0] ? -NRM_W'(q) : NRM_W'(q);
      2'd1:    nval = sgn[1] ? -NRM_W'(q) : NRM_W'(q);
      default: nval = sgn[2] ? -NRM_W'(q) : NRM_W'(q);
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      N_IDLE:      if (start) state_next = N_MAX;
      N_MAX:       state_next = N_SHIFT;
      N_SHIFT: begin
        if (m == '0) begin
          state_next = N_DONE;
        end else if (!m_big && !m_small) begin
          state_next = N_SQ;
        end
      end
      N_SQ:        if (sq_k == 2'd3) state_next = N_SQRT;
      N_SQRT:      if (bitv == 64'd1) state_next = N_DIV_INIT;
      N_DIV_INIT:  state_next = N_DIV_STEP;
      N_DIV_STEP:  if (dv_i == 4'd0) state_next = N_DIV_STORE;
      N_DIV_STORE: state_next = (dv_j == 2'd2) ? N_DONE : N_DIV_INIT;
      N_DONE:      state_next = N_IDLE;
      default:     state_next = N_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done = (state == N_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      N_IDLE: begin
        if (start) begin
          sgn[0] <= cvec.cx < 0;
          sgn[1] <= cvec.cy < 0;
          sgn[2] <= cvec.cz < 0;
          mag[0] <= (cvec.cx < 0) ? CROSS_W'(-cvec.cx) : CROSS_W'(cvec.cx);
          mag[1] <= (cvec.cy < 0) ? CROSS_W'(-cvec.cy) : CROSS_W'(cvec.cy);
          mag[2] <= (cvec.cz < 0) ? CROSS_W'(-cvec.cz) : CROSS_W'(cvec.cz);
          res    <= '0;
        end
      end
      N_MAX: begin
        m <= m_max;
      end
      N_SHIFT: begin
        sq_k <= 2'd0;
        sum  <= '0;
        if (m == '0) begin
          res.degenerate <= 1'b1;
        end else if (m_big) begin
          m      <= m >> 1;
          mag[0] <= mag[0] >> 1;
          mag[1] <= mag[1] >> 1;
          mag[2] <= mag[2] >> 1;
        end else if (m_small) begin
          m      <= m << 1;
          mag[0] <= mag[0] << 1;
          mag[1] <= mag[1] << 1;
          mag[2] <= mag[2] << 1;
        end
      end
      N_SQ: begin
        sq_prod <= sq_op * sq_op;
        if (sq_k != 2'd0) begin
          sum <= sum + 64'(sq_prod);
        end
        sq_k <= sq_k + 2'd1;
        if (sq_k == 2'd3) begin
          s_rem <= sum + 64'(sq_prod);
          root  <= '0;
          bitv  <= 64'd1 << 62;
        end
      end
      N_SQRT: begin
        if (s_rem >= trial_sq) begin
          s_rem <= s_rem - trial_sq;
          root  <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
        dv_j <= 2'd0;
      end
      N_DIV_INIT: begin
        if (dv_j == 2'd0) begin
          len <= root[31:0];
          rem <= (46'(dv_op) << NRM_FRAC) + 46'(root[31:1]);
        end else begin
          rem <= (46'(dv_op) << NRM_FRAC) + 46'(len >> 1);
        end
        dv_i <= 4'd14;
        q    <= '0;
      end
      N_DIV_STEP: begin
        if (rem >= trial_dv) begin
          rem     <= rem - trial_dv;
          q[dv_i] <= 1'b1;
        end
        dv_i <= dv_i - 4'd1;
      end
      N_DIV_STORE: begin
        unique case (dv_j)
          2'd0:    res.normal_x <= nval;
          2'd1:    res.normal_y <= nval;
          default: res.normal_z <= nval;
        endcase
        dv_j <= dv_j + 2'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/triangle_face_normal_unit.sv -----
// top level: vertex store, triangle sequencer and cross product
`default_nettype none

// triangle face normal unit
// one item at a time: an item is taken when start is high and busy is low,
// and its single result appears on result for exactly one cycle with
// result_valid high; the receiver cannot stall, so it must take it then.
// busy stays high from the cycle after start until the result cycle.
// a load writes the position and a zero normal, then emits its result; a read
// reads the normal memory, captures the word and emits; an item that does
// nothing goes straight to its result. a triangle does three position reads
// through the one read port of the position memory, six products through one
// shared multiplier, then the normalizer, whose bit-a-cycle shift, 32-step
// square root and three 15-step divisions dominate, and three writes through
// the one normal memory port; a zero cross product skips the root and divisions.
// flat_normals_enable is written through cfg_valid/cfg_data and resets to 1;
// it is to be written only while the block is idle, which the block does not enforce.
// memories hold no reset; a vertex must be loaded before it is used

module triangle_face_normal_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire tfn_pkg::req_t req,
  output logic               result_valid,
  output tfn_pkg::res_t      result,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic          cfg_data
);
  import tfn_pkg::*;

  tfn_state_t state, state_next;

  req_t req_q;
  res_t res_q;
  logic flat_en;

  // vertex store
  logic [3*POS_W-1:0] pos_mem [VERTEX_DEPTH];
  logic [3*POS_W-1:0] pos_q;
  logic [ADDR_W-1:0]  pos_raddr;
  logic               pos_we;
  logic [3*NRM_W-1:0] nrm_mem [VERTEX_DEPTH];
  logic [3*NRM_W-1:0] nrm_q;
  logic [3*NRM_W-1:0] nrm_wdata;
  logic [ADDR_W-1:0]  nrm_raddr;
  logic [ADDR_W-1:0]  nrm_waddr;
  logic               nrm_we;

  // gathered corners and edge vectors
  logic signed [POS_W-1:0]  p0 [3];
  logic signed [POS_W-1:0]  p1 [3];
  logic signed [DIFF_W-1:0] u [3];
  logic signed [DIFF_W-1:0] v [3];

  // shared multiplier for the cross product
  logic [2:0]               mul_k;
  logic [2:0]               mk1;
  logic signed [DIFF_W-1:0] mul_a;
  logic signed [DIFF_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  cross_t                   cr [3];

  logic       norm_start;
  logic       norm_done;
  res_t       norm_res;
  cross_vec_t cross_vec;

  logic tri_ok;

  assign cfg_ready = 1'b1;
  assign result    = res_q;

  assign tri_ok = flat_en && in_store(req.index_a) && in_store(req.index_b)
                  && in_store(req.index_c);

  assign cross_vec.cx = cr[0];
  assign cross_vec.cy = cr[1];
  assign cross_vec.cz = cr[2];

  assign mk1 = mul_k - 3'd1;

  // product order: x = u1v2 - u2v1, y = u2v0 - u0v2, z = u0v1 - u1v0
  always_comb begin
    unique case (mul_k)
      3'd0:    begin mul_a = u[1]; mul_b = v[2]; end
      3'd1:    begin mul_a = u[2]; mul_b = v[1]; end
      3'd2:    begin mul_a = u[2]; mul_b = v[0]; end
      3'd3:    begin mul_a = u[0]; mul_b = v[2]; end
      3'd4:    begin mul_a = u[0]; mul_b = v[1]; end
      3'd5:    begin mul_a = u[1]; mul_b = v[0]; end
      default: begin mul_a = '0;   mul_b = '0;   end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (req.req_type)
            REQ_LOAD: state_next = in_store(req.index_a) ? S_LOAD : S_EMIT;
            REQ_TRI:  state_next = tri_ok ? S_RD_A : S_EMIT;
            REQ_READ: state_next = in_store(req.index_a) ? S_RDN : S_EMIT;
            default:  state_next = S_EMIT;
          endcase
        end
      end
      S_LOAD:   state_next = S_EMIT;
      S_RDN:    state_next = S_RDN_W;
      S_RDN_W:  state_next = S_EMIT;
      S_RD_A:   state_next = S_RD_B;
      S_RD_B:   state_next = S_RD_C;
      S_RD_C:   state_next = S_CAP;
      S_CAP:    state_next = S_DIFF;
      S_DIFF:   state_next = S_MUL;
      S_MUL:    if (mul_k == 3'd6) state_next = S_NSTART;
      S_NSTART: state_next = S_NWAIT;
      S_NWAIT:  if (norm_done) state_next = S_WR_A;
      S_WR_A:   state_next = S_WR_B;
      S_WR_B:   state_next = S_WR_C;
      S_WR_C:   state_next = S_EMIT;
      S_EMIT:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // memory controls and handshake outputs
  always_comb begin
    busy         = (state != S_IDLE);
    result_valid = (state == S_EMIT);
    norm_start   = (state == S_NSTART);
    pos_we       = (state == S_LOAD);
    pos_raddr    = req_q.index_a[ADDR_W-1:0];
    nrm_raddr    = req_q.index_a[ADDR_W-1:0];
    nrm_we       = 1'b0;
    nrm_waddr    = req_q.index_a[ADDR_W-1:0];
    nrm_wdata    = {res_q.normal_x, res_q.normal_y, res_q.normal_z};
    unique case (state)
      S_LOAD: begin
        nrm_we    = 1'b1;
        nrm_wdata = '0;
      end
      S_RD_B:  pos_raddr = req_q.index_b[ADDR_W-1:0];
      S_RD_C:  pos_raddr = req_q.index_c[ADDR_W-1:0];
      S_WR_A:  nrm_we = 1'b1;
      S_WR_B: begin
        nrm_we    = 1'b1;
        nrm_waddr = req_q.index_b[ADDR_W-1:0];
      end
      S_WR_C: begin
        nrm_we    = 1'b1;
        nrm_waddr = req_q.index_c[ADDR_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[req_q.index_a[ADDR_W-1:0]] <= {req_q.pos_x, req_q.pos_y, req_q.pos_z};
    end
    pos_q <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (nrm_we) begin
      nrm_mem[nrm_waddr] <= nrm_wdata;
    end
    nrm_q <= nrm_mem[nrm_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      flat_en <= 1'b1;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        flat_en <= cfg_data;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          req_q <= req;
          res_q <= '0;
        end
        mul_k <= 3'd0;
      end
      S_RDN_W: begin
        res_q.normal_x <= nrm_q[3*NRM_W-1:2*NRM_W];
        res_q.normal_y <= nrm_q[2*NRM_W-1:NRM_W];
        res_q.normal_z <= nrm_q[NRM_W-1:0];
      end
      S_RD_B: begin
        p0[0] <= pos_q[3*POS_W-1:2*POS_W];
        p0[1] <= pos_q[2*POS_W-1:POS_W];
        p0[2] <= pos_q[POS_W-1:0];
      end
      S_RD_C: begin
        p1[0] <= pos_q[3*POS_W-1:2*POS_W];
        p1[1] <= pos_q[2*POS_W-1:POS_W];
        p1[2] <= pos_q[POS_W-1:0];
      end
      S_CAP: begin
        // third corner straight from the read port
        v[0] <= DIFF_W'($signed(pos_q[3*POS_W-1:2*POS_W])) - DIFF_W'(p0[0]);
        v[1] <= DIFF_W'($signed(pos_q[2*POS_W-1:POS_W])) - DIFF_W'(p0[1]);
        v[2] <= DIFF_W'($signed(pos_q[POS_W-1:0])) - DIFF_W'(p0[2]);
      end
      S_DIFF: begin
        u[0] <= DIFF_W'(p1[0]) - DIFF_W'(p0[0]);
        u[1] <= DIFF_W'(p1[1]) - DIFF_W'(p0[1]);
        u[2] <= DIFF_W'(p1[2]) - DIFF_W'(p0[2]);
      end
      S_MUL: begin
        prod  <= mul_a * mul_b;
        mul_k <= mul_k + 3'd1;
        // even products open a component, odd ones are subtracted
        if (mul_k != 3'd0) begin
          if (!mk1[0]) begin
            cr[mk1[2:1]] <= CROSS_W'(prod);
          end else begin
            cr[mk1[2:1]] <= cr[mk1[2:1]] - CROSS_W'(prod);
          end
        end
      end
      S_NWAIT: begin
        if (norm_done) begin
          res_q <= norm_res;
        end
      end
      default: begin
      end
    endcase
  end

  tfn_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .cvec  (cross_vec),
    .done  (norm_done),
    .res   (norm_res)
  );

endmodule

`default_nettype wire

// ----- hdl/tfn_checker.sv -----
// port checker for the triangle face normal unit and its bind
`default_nettype none

module tfn_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          result_valid,
  input wire tfn_pkg::res_t result
);

  // result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe longer than one cycle");

  // an accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // a result only ends a busy period
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (busy ##1 !busy))
    else $error("result outside a busy period");

  // degenerate results carry a zero normal
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.degenerate) |->
      (result.normal_x == 0 && result.normal_y == 0 && result.normal_z == 0))
    else $error("degenerate result with nonzero normal");

  // idle after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy)
    else $error("busy after reset");

endmodule

bind triangle_face_normal_unit tfn_checker u_tfn_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);

`default_nettype wire

// ----- sim/triangle_face_normal_unit_tb.sv -----
// testbench of the triangle face normal unit: directed table, then random traffic
`default_nettype none

module triangle_face_normal_unit_tb;
  import tfn_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 1500000;
  localparam int NVTX = 16;  // vertices used by most random traffic
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic result_valid;
  res_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_data;

  triangle_face_normal_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .result_valid(result_valid), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state: its own vertex store and the enable copy
  logic signed [POS_W-1:0] pos_mem [VERTEX_DEPTH][3];
  logic signed [NRM_W-1:0] nrm_mem [VERTEX_DEPTH][3];
  bit                      loaded  [VERTEX_DEPTH];
  logic                    flat_en;

  res_t normals_due [$];
  int   errors;
  int   cycle = 0;

  // directed rows
  typedef struct {
    req_t r;
    bit   known;   // expected result typed in
    res_t exp_res;
  } row_t;
  row_t plan [$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // integer square root, bit by bit
  function automatic longint unsigned root_floor(input longint unsigned s);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // flat normal of a triangle from the predictor store
  function automatic res_t face_normal(input int ia, input int ib, input int ic);
    longint u [3];
    longint v [3];
    longint c [3];
    longint unsigned a [3];
    longint unsigned m;
    longint unsigned sum;
    longint unsigned len;
    longint q;
    res_t o;
    o = '0;
    for (int i = 0; i < 3; i++) begin
      u[i] = longint'(pos_mem[ib][i]) - longint'(pos_mem[ia][i]);
      v[i] = longint'(pos_mem[ic][i]) - longint'(pos_mem[ia][i]);
    end
    c[0] = u[1] * v[2] - u[2] * v[1];
    c[1] = u[2] * v[0] - u[0] * v[2];
    c[2] = u[0] * v[1] - u[1] * v[0];
    m = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = (c[i] < 0) ? longint'(-c[i]) : c[i];
      if (a[i] > m) m = a[i];
    end
    if (m == 0) begin
      o.degenerate = 1'b1;
      return o;
    end
    while (m >= (64'd1 << 30)) begin
      m >>= 1;
      for (int i = 0; i < 3; i++) a[i] >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) a[i] <<= 1;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) sum += a[i] * a[i];
    len = root_floor(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((a[i] << NRM_FRAC) + (len >> 1)) / len;
      if (c[i] < 0) q = -q;
      if (i == 0) o.normal_x = q[NRM_W-1:0];
      if (i == 1) o.normal_y = q[NRM_W-1:0];
      if (i == 2) o.normal_z = q[NRM_W-1:0];
    end
    return o;
  endfunction

  // advance the predictor by one item, return its result
  function automatic res_t predict_item(input req_t r);
    res_t o;
    int ia, ib, ic;
    o = '0;
    ia = int'(r.index_a);
    ib = int'(r.index_b);
    ic = int'(r.index_c);
    case (r.req_type)
      REQ_LOAD: begin
        pos_mem[ia][0] = r.pos_x;
        pos_mem[ia][1] = r.pos_y;
        pos_mem[ia][2] = r.pos_z;
        for (int i = 0; i < 3; i++) nrm_mem[ia][i] = '0;
        loaded[ia] = 1'b1;
      end
      REQ_TRI: begin
        if (flat_en) begin
          o = face_normal(ia, ib, ic);
          for (int i = 0; i < 3; i++) begin
            nrm_mem[ia][i] = (i == 0) ? o.normal_x : (i == 1) ? o.normal_y : o.normal_z;
            nrm_mem[ib][i] = nrm_mem[ia][i];
            nrm_mem[ic][i] = nrm_mem[ia][i];
          end
          loaded[ia] = 1'b1;
          loaded[ib] = 1'b1;
          loaded[ic] = 1'b1;
        end
      end
      REQ_READ: begin
        o.normal_x = nrm_mem[ia][0];
        o.normal_y = nrm_mem[ia][1];
        o.normal_z = nrm_mem[ia][2];
      end
      default: ;
    endcase
    return o;
  endfunction

  // compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (normals_due.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, result);
        errors++;
      end else begin
        res_t e;
        e = normals_due.pop_front();
        if (result.normal_x !== e.normal_x || result.normal_y !== e.normal_y ||
            result.normal_z !== e.normal_z || result.degenerate !== e.degenerate) begin
          $display("%0t: result mismatch expected %0d %0d %0d d%0b actual %0d %0d %0d d%0b",
                   $realtime, e.normal_x, e.normal_y, e.normal_z, e.degenerate,
                   result.normal_x, result.normal_y, result.normal_z, result.degenerate);
          errors++;
        end
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT_CYCLES) begin
      $display("** triangle_face_normal_unit: FAILED **");
      $finish;
    end
  end

  // sender burst bookkeeping
  int burst_left;
  int gap_left;

  // send one item; the expectation is queued as it is taken
  // start stays high between items of one burst
  task automatic send_item(input req_t r, input bit known, input res_t kres);
    res_t p;
    if (burst_left == 0) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        repeat (gap_left) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
    end
    burst_left--;
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    // taken at this edge
    p = predict_item(r);
    if (known && p !== kres) begin
      $display("%0t: predictor disagrees with table expected %p got %p", $realtime, kres, p);
      errors++;
    end
    normals_due = {normals_due, (known ? kres : p)};
  endtask

  task automatic drain();
    int n;
    n = 0;
    start <= 1'b0;
    while (normals_due.size() != 0 && n < 2000) begin
      @(posedge clk);
      n++;
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic write_enable(input logic v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    flat_en = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic req_t mk(input logic [1:0] t, input int a, input int b, input int c,
                              input int x, input int y, input int z);
    req_t r;
    r.req_type = t;
    r.index_a = IDX_W'(a);
    r.index_b = IDX_W'(b);
    r.index_c = IDX_W'(c);
    r.pos_x = POS_W'(x);
    r.pos_y = POS_W'(y);
    r.pos_z = POS_W'(z);
    return r;
  endfunction

  function automatic res_t nv(input int x, input int y, input int z, input bit d);
    res_t o;
    o.normal_x = NRM_W'(x);
    o.normal_y = NRM_W'(y);
    o.normal_z = NRM_W'(z);
    o.degenerate = d;
    return o;
  endfunction

  function automatic int rand_pos();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 8000) - 4000;
      1: return -8388608;
      2: return 8388607;
      default: return int'({{8{1'b0}}, 24'($urandom)}) - 8388608;
    endcase
  endfunction

  // random index among loaded vertices, mostly from a small pool
  function automatic int pick_loaded();
    int k;
    for (int t = 0; t < 50; t++) begin
      k = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, VERTEX_DEPTH - 1))
                                     : int'($urandom_range(0, NVTX - 1));
      if (loaded[k]) return k;
    end
    return 0;
  endfunction

  function automatic void add(input req_t r);
    row_t w;
    w.r = r;
    w.known = 1'b0;
    w.exp_res = '0;
    plan = {plan, w};
  endfunction

  function automatic void add_known(input req_t r, input res_t e);
    row_t w;
    w.r = r;
    w.known = 1'b1;
    w.exp_res = e;
    plan = {plan, w};
  endfunction

  initial begin
    req_t r;
    int sent;
    errors = 0;
    flat_en = 1'b1;
    burst_left = 0;
    gap_left = 0;
    rst <= 1'b1;
    start <= 1'b0;
    req <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= 1'b0;
    foreach (loaded[i]) loaded[i] = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: loads at the index and position extremes
    add_known(mk(REQ_LOAD, 0, 0, 0, 0, 0, 0), nv(0, 0, 0, 0));
    add_known(mk(REQ_LOAD, 1, 4095, 4095, 4096, 0, 0), nv(0, 0, 0, 0));
    add_known(mk(REQ_LOAD, 2, 0, 0, 0, 4096, 0), nv(0, 0, 0, 0));
    add_known(mk(REQ_LOAD, 4095, 0, 0, -8388608, -8388608, -8388608), nv(0, 0, 0, 0));
    add_known(mk(REQ_LOAD, 4094, 0, 0, 8388607, 8388607, 8388607), nv(0, 0, 0, 0));
    add_known(mk(REQ_LOAD, 4093, 0, 0, 8388607, -8388608, 0), nv(0, 0, 0, 0));
    // freshly loaded vertex reads back a zero normal
    add_known(mk(REQ_READ, 4095, 7, 7, 0, 0, 0), nv(0, 0, 0, 0));
    // unit right triangle in the xy plane: normal +z
    add_known(mk(REQ_TRI, 0, 1, 2, 0, 0, 0), nv(0, 0, 16384, 0));
    add_known(mk(REQ_READ, 2, 0, 0, 0, 0, 0), nv(0, 0, 16384, 0));
    // reversed winding: normal -z, last write wins
    add_known(mk(REQ_TRI, 0, 2, 1, 0, 0, 0), nv(0, 0, -16384, 0));
    add_known(mk(REQ_READ, 1, 0, 0, 0, 0, 0), nv(0, 0, -16384, 0));
    // repeated corner: zero cross product
    add_known(mk(REQ_TRI, 0, 0, 1, 0, 0, 0), nv(0, 0, 0, 1));
    add_known(mk(REQ_READ, 0, 0, 0, 0, 0, 0), nv(0, 0, 0, 0));
    // largest coordinates spread
    add(mk(REQ_TRI, 4095, 4094, 4093, 0, 0, 0));
    add(mk(REQ_READ, 4094, 0, 0, 0, 0, 0));
    add(mk(REQ_TRI, 4093, 0, 4095, 0, 0, 0));
    // reload clears the normal
    add_known(mk(REQ_LOAD, 4093, 0, 0, 8388607, -8388608, 0), nv(0, 0, 0, 0));
    add_known(mk(REQ_READ, 4093, 0, 0, 0, 0, 0), nv(0, 0, 0, 0));
    // unknown request type does nothing
    add_known(mk(REQ_UNKNOWN, 4095, 4095, 4095, -1, -1, -1), nv(0, 0, 0, 0));
    foreach (plan[i]) send_item(plan[i].r, plan[i].known, plan[i].exp_res);

    // disabled: triangles do nothing, vertex 1 keeps the zero from the degenerate triangle
    write_enable(1'b0);
    send_item(mk(REQ_TRI, 0, 1, 2, 0, 0, 0), 1'b1, nv(0, 0, 0, 0));
    send_item(mk(REQ_READ, 1, 0, 0, 0, 0, 0), 1'b1, nv(0, 0, 0, 0));
    write_enable(1'b1);

    // seed the small pool
    for (int k = 0; k < NVTX; k++)
      send_item(mk(REQ_LOAD, k, 0, 0, rand_pos(), rand_pos(), rand_pos()), 1'b0, '0);

    sent = 0;
    while (sent < 1400) begin
      if (sent == 400) write_enable(1'b0);
      if (sent == 500) write_enable(1'b1);
      if (sent == 900) drain();  // pause until everything is back
      r = '0;
      r.index_b = IDX_W'($urandom);
      r.index_c = IDX_W'($urandom);
      r.pos_x = POS_W'($urandom);
      r.pos_y = POS_W'($urandom);
      r.pos_z = POS_W'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          r.req_type = REQ_LOAD;
          r.index_a = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom)
                                                 : IDX_W'($urandom_range(0, NVTX - 1));
          r.pos_x = POS_W'(rand_pos());
          r.pos_y = POS_W'(rand_pos());
          r.pos_z = POS_W'(rand_pos());
        end
        3, 4, 5: begin
          r.req_type = REQ_TRI;
          r.index_a = IDX_W'(pick_loaded());
          r.index_b = ($urandom_range(0, 15) == 0) ? r.index_a : IDX_W'(pick_loaded());
          r.index_c = IDX_W'(pick_loaded());
        end
        6, 7, 8: begin
          r.req_type = REQ_READ;
          r.index_a = IDX_W'(pick_loaded());
        end
        default: begin
          r.req_type = REQ_UNKNOWN;
          r.index_a = IDX_W'($urandom);
        end
      endcase
      send_item(r, 1'b0, '0);
      sent++;
    end

    drain();
    if (errors == 0 && normals_due.size() == 0) begin
      $display("** triangle_face_normal_unit: PASSED **");
    end else begin
      $display("** triangle_face_normal_unit: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
